/* rtl/hmd_pkg.sv */
// ----------------------------------------------------------------------------
// hmd_pkg: shared types and constants for the Hamming(7,4) letter decryptor
// Payload structs and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package hmd_pkg;

	localparam int CodeW   = 7;
	localparam int SynW    = 3;
	localparam int MsgW    = 4;
	localparam int CfgIdxW = 2;
	localparam int CfgDatW = 28;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PARITY     = 2'd0,
		CFG_SYN_TABLE  = 2'd1,
		CFG_DECODE     = 2'd2,
		CFG_UNSCRAMBLE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CodeW-1:0] code_low;
		logic [CodeW-1:0] code_high;
	} cipher_t;

	typedef struct packed {
		logic [CodeW-1:0] plain_letter;
		logic [CodeW-1:0] fixed_low;
		logic [CodeW-1:0] fixed_high;
	} result_t;

	typedef struct packed {
		logic [3*CodeW-1:0] parity_matrix;
		logic [SynW*CodeW-1:0] syndrome_table;
		logic [MsgW*CodeW-1:0] decode_matrix;
		logic [MsgW*MsgW-1:0] unscramble_matrix;
	} key_t;

	typedef struct packed {
		logic [CodeW-1:0] fixed;
		logic [MsgW-1:0]  rec;
	} lane_res_t;

endpackage

`default_nettype wire

/* rtl/hamming74_mceliece_byte_decrypt.sv */
// ----------------------------------------------------------------------------
// hamming74_mceliece_byte_decrypt: two-lane Hamming(7,4) letter decryptor
// Both codeword halves decode in parallel lanes; a merge stage forms the
// letter from the recovered nibbles and registers the result.
//
// Channel  | Signals                                  | Transaction
// input    | start, busy, cipher                      | start & !busy
// result   | result_valid, result                     | result_valid
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
//
// One ciphertext per cycle; result_valid follows start through valid_s1 and valid_s2.
// busy is always low; the lane registers and merge register set the latency.
// Reset clears the key registers to zero and the valid pipeline.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming74_mceliece_byte_decrypt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire hmd_pkg::cipher_t              cipher,
	output logic                               result_valid,
	output hmd_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hmd_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [hmd_pkg::CfgDatW-1:0]   cfg_data
);
	import hmd_pkg::*;

	key_t      key_q;
	logic      valid_s1;
	logic      valid_s2;
	lane_res_t lo_s1;
	lane_res_t hi_s1;
	result_t   result_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PARITY:     key_q.parity_matrix     <= cfg_data[3*CodeW-1:0];
				CFG_SYN_TABLE:  key_q.syndrome_table    <= cfg_data[SynW*CodeW-1:0];
				CFG_DECODE:     key_q.decode_matrix     <= cfg_data[MsgW*CodeW-1:0];
				CFG_UNSCRAMBLE: key_q.unscramble_matrix <= cfg_data[MsgW*MsgW-1:0];
				default: ;
			endcase
		end
	end

	hmd_lane u_lane_lo (
		.clk    (clk),
		.code   (cipher.code_low),
		.key    (key_q),
		.res_s1 (lo_s1)
	);

	hmd_lane u_lane_hi (
		.clk    (clk),
		.code   (cipher.code_high),
		.key    (key_q),
		.res_s1 (hi_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_s2.plain_letter <= {hi_s1.rec[CodeW-MsgW-1:0], lo_s1.rec};
		result_s2.fixed_low    <= lo_s1.fixed;
		result_s2.fixed_high   <= hi_s1.fixed;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

`default_nettype wire

/* rtl/hmd_lane.sv */
// ----------------------------------------------------------------------------
// hmd_lane: one codeword lane
// Syndrome, error flip, message decode and unscramble, registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module hmd_lane (
	input  wire logic                          clk,
	input  wire logic [hmd_pkg::CodeW-1:0]     code,
	input  wire hmd_pkg::key_t                 key,
	output hmd_pkg::lane_res_t                 res_s1
);
	import hmd_pkg::*;

	logic [SynW-1:0]  syn;
	logic [CodeW-1:0] word;
	logic [MsgW-1:0]  dec;
	logic [MsgW-1:0]  rec;

	always_comb begin
		for (int i = 0; i < SynW; i++) begin
			syn[SynW-1-i] = ^(key.parity_matrix[CodeW*i +: CodeW] & code);
		end
		for (int i = 0; i < CodeW; i++) begin
			word[i] = code[i] ^ (key.syndrome_table[SynW*i +: SynW] == syn);
		end
		for (int i = 0; i < MsgW; i++) begin
			dec[i] = ^(key.decode_matrix[CodeW*i +: CodeW] & word);
		end
		for (int i = 0; i < MsgW; i++) begin
			rec[i] = 1'b0;
			for (int j = 0; j < MsgW; j++) begin
				rec[i] = rec[i] ^ (key.unscramble_matrix[i + MsgW*j] & dec[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s1.fixed <= word;
		res_s1.rec   <= rec;
	end

endmodule

`default_nettype wire
